// ===== hw/rtl/npp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// npp_pkg: shared types and constants for the nearest palette pixel packer.
// Used by npp_cell, npp_packer and nearest_palette_pixel_packer_unit.

package npp_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int INDEX_W       = 8;
   localparam int USED_W        = 9;
   localparam int SCORE_W       = 13;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // larger than any real score (max 4095)
   localparam logic [SCORE_W-1:0] SCORE_INIT = 13'd4096;
   localparam logic [SCORE_W-1:0] SCORE_MAX  = 13'd4095;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // register select is byte address bit 2
   localparam logic REG_DEPTH_LOG2  = 1'b0;
   localparam logic REG_ENTRY_COUNT = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               command;
      logic [INDEX_W-1:0] entry_index;
      logic [3:0]         red;
      logic [3:0]         green;
      logic [3:0]         blue;
      logic               last_pixel;
      logic [SCORE_W-1:0] best_score;
      logic [INDEX_W-1:0] best_index;
   } token_type;

endpackage

`default_nettype wire

// ===== hw/rtl/npp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// npp_cell: one palette slot of the search chain plus one token stage.
// Depends on npp_pkg (token_type, widths).

module npp_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [npp_pkg::INDEX_W-1:0]  cell_index,
   input  wire logic [npp_pkg::USED_W-1:0]   entries_used,
   input  wire npp_pkg::token_type           tok_in,
   output npp_pkg::token_type                tok_out
);
   import npp_pkg::*;

   logic [11:0]        entry_ff;
   token_type          tok_ff;
   token_type          tok_in_next;
   logic signed [4:0]  dr;
   logic signed [4:0]  dg;
   logic signed [4:0]  db;
   logic signed [12:0] sum;
   logic [SCORE_W-1:0] score;
   logic               active;
   logic               load_hit;

   // differences are entry minus pixel
   assign dr = $signed({1'b0, entry_ff[11:8]}) - $signed({1'b0, tok_in.red});
   assign dg = $signed({1'b0, entry_ff[7:4]})  - $signed({1'b0, tok_in.green});
   assign db = $signed({1'b0, entry_ff[3:0]})  - $signed({1'b0, tok_in.blue});

   assign sum = $signed({{4{dr[4]}}, dr, 4'b0000})
              + $signed({dg, 8'h00})
              + $signed({{8{db[4]}}, db});

   always_comb begin
      if (sum[12]) begin
         score = 13'(-sum);
      end else begin
         score = 13'(sum);
      end
   end

   assign active   = (tok_in.command == CMD_PIXEL)
                   && ({1'b0, cell_index} < entries_used);
   assign load_hit = tok_in.valid && (tok_in.command == CMD_LOAD)
                   && (tok_in.entry_index == cell_index);

   always_comb begin
      tok_in_next = tok_in;
      if (active && (score < tok_in.best_score)) begin
         tok_in_next.best_score = score;
         tok_in_next.best_index = cell_index;
      end
   end

   // palette slot: no reset, contents undefined until loaded
   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         entry_ff <= {tok_in.red, tok_in.green, tok_in.blue};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

`ifndef SYNTH
   a_score_never_grows: assert property (@(posedge clock) disable iff (reset)
      advance && tok_in.valid |=> tok_ff.best_score <= $past(tok_in.best_score))
      else $error("best score grew across a cell");

   a_index_from_this_cell: assert property (@(posedge clock) disable iff (reset)
      advance && tok_in.valid |=> (tok_ff.best_index == $past(tok_in.best_index))
                                  || (tok_ff.best_index == cell_index))
      else $error("best index taken from a foreign cell");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/npp_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// npp_packer: masks winning indices to bpp bits, packs them into bytes and
// holds the result register. Depends on npp_pkg.

module npp_packer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire npp_pkg::token_type tok,
   input  wire logic [1:0]         depth_log2,
   output logic                    advance,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_packed_byte,
   output logic                    rsp_image_end
);
   import npp_pkg::*;

   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   logic [2:0] slot_ff;
   logic [2:0] slot_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic [7:0] rsp_byte_in;
   logic       rsp_end_ff;
   logic       rsp_end_in;
   logic [7:0] idx_mask;
   logic [7:0] idx_m;
   logic [5:0] shift;
   logic [7:0] acc_new;
   logic [2:0] slot_next;
   logic [3:0] per_byte;
   logic       take_pixel;
   logic       emit;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (depth_log2)
         2'd0:    idx_mask = 8'h01;
         2'd1:    idx_mask = 8'h03;
         2'd2:    idx_mask = 8'h0F;
         default: idx_mask = 8'hFF;
      endcase
   end

   assign idx_m     = tok.best_index & idx_mask;
   assign shift     = 6'(slot_ff) << depth_log2;
   assign per_byte  = 4'(4'd8 >> depth_log2);
   assign slot_next = slot_ff + 3'd1;
   // slots beyond bit 7 (after a depth change) drop their bits
   assign acc_new   = (shift < 6'd8) ? (acc_ff | 8'(idx_m << shift[2:0])) : acc_ff;
   assign take_pixel = advance && tok.valid && (tok.command == CMD_PIXEL);
   assign emit = tok.last_pixel || (slot_next == 3'd0) || ({1'b0, slot_next} >= per_byte);

   always_comb begin
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (take_pixel) begin
         if (emit) begin
            acc_in       = 8'h00;
            slot_in      = 3'd0;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = acc_new;
            rsp_end_in   = tok.last_pixel;
         end else begin
            acc_in  = acc_new;
            slot_in = slot_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 8'h00;
         slot_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_image_end   = rsp_end_ff;

`ifndef SYNTH
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      take_pixel && emit |=> (slot_ff == 3'd0) && (acc_ff == 8'h00) && rsp_valid_ff)
      else $error("accumulator not cleared after a byte was emitted");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_palette_pixel_packer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Nearest palette pixel packer, top level.
// req channel (valid/ready): command 0 loads palette slot entry_index with
// red/green/blue; command 1 converts one pixel, last_pixel ends the image.
// rsp channel (valid/ready): one packed byte of palette indices, first pixel
// in the lowest bits; image_end marks the byte holding the last pixel.
// csr port (APB-style, pready always high): 0x0 depth_log2, 0x4 entry count.
// Every transaction walks a chain of PALETTE_DEPTH cells, one cell per cycle
// while rsp is not stalled; each cell owns one palette slot and scores the
// pixel against it. The packer registers a byte for rsp when the pixel that
// completes it leaves the last cell; one transaction per cycle unless stalled.
// Loads travel the same chain, so later pixels always see earlier loads.
// Reset empties the chain and packer and sets depth_log2=3, entry count=0;
// palette contents are undefined until loaded.
// While rsp is stalled with a byte held, the whole chain and req_ready hold.
// Depends on npp_pkg, npp_cell, npp_packer.

module nearest_palette_pixel_packer_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_command,
   input  wire logic [7:0]                       req_entry_index,
   input  wire logic [3:0]                       req_red,
   input  wire logic [3:0]                       req_green,
   input  wire logic [3:0]                       req_blue,
   input  wire logic                             req_last_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_packed_byte,
   output logic                                  rsp_image_end,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [npp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [npp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [npp_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import npp_pkg::*;

   logic [1:0]        depth_log2_ff;
   logic [USED_W-1:0] entries_used_ff;
   logic              csr_write;
   logic              advance;
   token_type         chain [PALETTE_DEPTH+1];

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_log2_ff   <= 2'd3;
         entries_used_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_DEPTH_LOG2) begin
            depth_log2_ff <= csr_pwdata[1:0];
         end else begin
            entries_used_ff <= csr_pwdata[USED_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_ENTRY_COUNT) begin
         csr_prdata = CSR_DATA_W'(entries_used_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(depth_log2_ff);
      end
   end

   // chain entry
   assign req_ready = advance;

   always_comb begin
      chain[0].valid       = req_valid;
      chain[0].command     = req_command;
      chain[0].entry_index = req_entry_index;
      chain[0].red         = req_red;
      chain[0].green       = req_green;
      chain[0].blue        = req_blue;
      chain[0].last_pixel  = req_last_pixel;
      chain[0].best_score  = SCORE_INIT;
      chain[0].best_index  = '0;
   end

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      npp_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .cell_index   (INDEX_W'(k)),
         .entries_used (entries_used_ff),
         .tok_in       (chain[k]),
         .tok_out      (chain[k+1])
      );
   end

   npp_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .tok             (chain[PALETTE_DEPTH]),
      .depth_log2      (depth_log2_ff),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_image_end   (rsp_image_end)
   );

`ifndef SYNTH
   a_pixel_found_entry: assert property (@(posedge clock) disable iff (reset)
      chain[PALETTE_DEPTH].valid && (chain[PALETTE_DEPTH].command == CMD_PIXEL)
      && (entries_used_ff != '0) |-> chain[PALETTE_DEPTH].best_score <= SCORE_MAX)
      else $error("pixel left the chain without a scored entry");

   a_index_in_used_range: assert property (@(posedge clock) disable iff (reset)
      chain[PALETTE_DEPTH].valid && (chain[PALETTE_DEPTH].command == CMD_PIXEL)
      |-> ({1'b0, chain[PALETTE_DEPTH].best_index} < entries_used_ff)
          || (chain[PALETTE_DEPTH].best_index == '0))
      else $error("winning index outside the searched entries");
`endif

endmodule

`default_nettype wire
